// File: rtl/sfdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_pkg
// shared sizes, codes and control types of the spi frame deframer queue
// ----------------------------------------------------------------------------
package sfdq_pkg;

  localparam int FRAME_BYTES  = 8;
  localparam int QUEUE_FRAMES = 4;

  localparam int STORE_DEPTH = FRAME_BYTES * QUEUE_FRAMES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = $clog2(QUEUE_FRAMES);
  localparam int BYTE_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_FRAMES + 1);

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  localparam logic [7:0] START_PATTERN_RESET = 8'd126;

  // register select, taken from paddr[2]
  localparam logic REG_START_PATTERN = 1'b0;

  typedef enum logic [1:0] {
    CMD_XFER,
    CMD_POP,
    CMD_TXW,
    CMD_SEND
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_FULL,
    STAT_BUSY
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic rd_issue;
    logic rd_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic pop_hit;
    logic out_free;
    logic byte_last;
  } dp_sts_t;

endpackage

// File: rtl/sfdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sfdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sfdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_ctrl
// sequencer: accepts one transaction, runs it, streams popped frames
// ----------------------------------------------------------------------------
module sfdq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  sfdq_pkg::dp_sts_t    sts,
  output sfdq_pkg::ctl_cmd_t   ctl
);
  import sfdq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.pop_hit) begin
          ctl.execute = 1'b1;
          state_next  = S_POP_RD;
        end else if (sts.out_free) begin
          ctl.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_POP_RD: begin
        ctl.rd_issue = 1'b1;
        state_next   = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (sts.out_free) begin
          ctl.rd_load = 1'b1;
          state_next  = sts.byte_last ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/sfdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_datapath
// queue pointers, receive and send state, transmit buffer, result register
// ----------------------------------------------------------------------------
module sfdq_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [sfdq_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sfdq_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_wdata,
  output logic [7:0]                       start_pattern,
  input  sfdq_pkg::ctl_cmd_t               ctl,
  output sfdq_pkg::dp_sts_t                sts
);
  import sfdq_pkg::*;

  // captured transaction
  cmd_t        in_cmd;
  logic [7:0]  in_rx;
  logic [4:0]  in_idx;
  logic [7:0]  in_data;

  // queue and link state
  logic [SLOT_W-1:0]  write_slot, write_slot_next;
  logic [SLOT_W-1:0]  read_slot, read_slot_next;
  logic [COUNT_W-1:0] frame_count, frame_count_next;
  logic [BYTE_W-1:0]  rx_position, rx_position_next;
  logic               frame_armed, frame_armed_next;
  logic [BYTE_W-1:0]  tx_position, tx_position_next;
  logic               sending, sending_next;
  logic [7:0]         tx_buf [FRAME_BYTES];

  // pop streaming
  logic [SLOT_W-1:0]  pop_slot;
  logic [BYTE_W-1:0]  byte_idx;

  // result register
  logic               o_txv;
  logic [7:0]         o_txb;
  logic [7:0]         o_fb;
  logic               o_last;
  status_t            o_st;
  logic [COUNT_W-1:0] o_held;
  logic               o_busy;

  // execute results
  logic               x_txv;
  logic [7:0]         x_txb;
  status_t            x_st;
  logic               store_hit;
  logic               buf_hit;
  logic               queue_full;

  logic                out_load;
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [STORE_AW-1:0] store_raddr;
  logic [7:0]          store_rdata;

  assign queue_full    = (frame_count == COUNT_W'(QUEUE_FRAMES));
  assign sts.pop_hit   = (in_cmd == CMD_POP) && (frame_count != '0);
  assign sts.out_free  = !m_tvalid || m_tready;
  assign sts.byte_last = (byte_idx == BYTE_W'(FRAME_BYTES - 1));

  always_comb begin
    write_slot_next  = write_slot;
    read_slot_next   = read_slot;
    frame_count_next = frame_count;
    rx_position_next = rx_position;
    frame_armed_next = frame_armed;
    tx_position_next = tx_position;
    sending_next     = sending;
    x_txv            = 1'b0;
    x_txb            = '0;
    x_st             = STAT_OK;
    store_hit        = 1'b0;
    buf_hit          = 1'b0;
    case (in_cmd)
      CMD_XFER: begin
        if (queue_full) begin
          x_st = STAT_FULL;
        end else if (frame_armed) begin
          store_hit = 1'b1;
          if (rx_position == BYTE_W'(FRAME_BYTES - 1)) begin
            rx_position_next = '0;
            write_slot_next  = (write_slot == SLOT_W'(QUEUE_FRAMES - 1)) ? '0
                                                                         : write_slot + 1'b1;
            frame_count_next = frame_count + 1'b1;
            frame_armed_next = 1'b0;
          end else begin
            rx_position_next = rx_position + 1'b1;
          end
        end
        if (in_rx == start_pattern) begin
          frame_armed_next = 1'b1;
        end
        if (sending) begin
          x_txv = 1'b1;
          x_txb = tx_buf[tx_position];
          if (tx_position == BYTE_W'(FRAME_BYTES - 1)) begin
            sending_next     = 1'b0;
            tx_position_next = '0;
          end else begin
            tx_position_next = tx_position + 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (frame_count == '0) begin
          x_st = STAT_EMPTY;
        end else begin
          read_slot_next   = (read_slot == SLOT_W'(QUEUE_FRAMES - 1)) ? '0
                                                                      : read_slot + 1'b1;
          frame_count_next = frame_count - 1'b1;
        end
      end
      CMD_TXW: begin
        if (sending) begin
          x_st = STAT_BUSY;
        end else if ({1'b0, in_idx} < 6'(FRAME_BYTES)) begin
          buf_hit = 1'b1;
        end
      end
      CMD_SEND: begin
        if (sending) begin
          x_st = STAT_BUSY;
        end else begin
          sending_next     = 1'b1;
          tx_position_next = '0;
          x_txv            = 1'b1;
          x_txb            = start_pattern;
        end
      end
      default: begin
        x_st = STAT_OK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern <= START_PATTERN_RESET;
      write_slot    <= '0;
      read_slot     <= '0;
      frame_count   <= '0;
      rx_position   <= '0;
      frame_armed   <= 1'b0;
      tx_position   <= '0;
      sending       <= 1'b0;
      tx_buf        <= '{default: '0};
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_pattern <= cfg_wdata;
      end
      if (ctl.execute) begin
        write_slot  <= write_slot_next;
        read_slot   <= read_slot_next;
        frame_count <= frame_count_next;
        rx_position <= rx_position_next;
        frame_armed <= frame_armed_next;
        tx_position <= tx_position_next;
        sending     <= sending_next;
        if (buf_hit) begin
          tx_buf[in_idx[BYTE_W-1:0]] <= in_data;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign out_load = (ctl.execute && !sts.pop_hit) || ctl.rd_load;

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_rx   <= s_tdata[7:0];
      in_idx  <= s_tdata[12:8];
      in_data <= s_tdata[20:13];
    end
    if (ctl.execute) begin
      pop_slot <= read_slot;
      byte_idx <= '0;
    end else if (ctl.rd_load) begin
      byte_idx <= byte_idx + 1'b1;
    end
    if (ctl.execute && !sts.pop_hit) begin
      o_txv  <= x_txv;
      o_txb  <= x_txb;
      o_fb   <= '0;
      o_last <= 1'b1;
      o_st   <= x_st;
      o_held <= frame_count_next;
      o_busy <= sending_next;
    end else if (ctl.rd_load) begin
      o_txv  <= 1'b0;
      o_txb  <= '0;
      o_fb   <= store_rdata;
      o_last <= sts.byte_last;
      o_st   <= STAT_OK;
      o_held <= frame_count;
      o_busy <= sending;
    end
  end

  // frame store addressing: slot * FRAME_BYTES + byte
  assign store_we    = ctl.execute && store_hit;
  assign store_waddr = STORE_AW'(STORE_AW'(write_slot) * STORE_AW'(FRAME_BYTES)
                                 + STORE_AW'(rx_position));
  assign store_raddr = STORE_AW'(STORE_AW'(pop_slot) * STORE_AW'(FRAME_BYTES)
                                 + STORE_AW'(byte_idx));

  sfdq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (in_rx),
    .re    (ctl.rd_issue),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  assign m_tdata = {1'b0, o_busy, 5'(o_held), o_fb, o_txb, o_txv};
  assign m_tuser = o_st;
  assign m_tlast = o_last;

endmodule

// File: rtl/spi_frame_deframer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_frame_deframer_queue
// spi byte link front end: start-byte framing, frame queue and frame sender
// ----------------------------------------------------------------------------
// usage
//   s_* channel carries one command per transaction (tuser = command):
//   transfer event, pop frame, write transmit byte, start send.
//   m_* channel returns results; tlast marks the final result of a command,
//   tuser carries the status code.
//   apb port holds the start pattern register at address 0 (reset 126).
// timing
//   single-result commands: captured, then executed and the result registered
//   once the output register is free; the next command is taken back in idle.
//   pop of a held frame: after exec, each of the FRAME_BYTES results takes a
//   read state and an output state, set by the registered read of the frame
//   store ram; no new command is taken until the last byte is loaded.
// reset
//   clears queue pointers, frame count, receive and send state and the
//   transmit buffer; the frame store is not cleared and needs no sweep,
//   only completed frames are ever read.
// stall
//   a result waits in the output register while m_tready is low; one more
//   command is accepted; bar a non-empty pop, it runs once the slot frees.
// ----------------------------------------------------------------------------
module spi_frame_deframer_queue (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] rx_byte, [12:8] tx_index, [20:13] tx_data, [23:21] zero
  input  logic [sfdq_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] command
  input  logic [1:0]                     s_tuser,
  // master stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] tx_valid, [8:1] tx_byte, [16:9] frame_byte, [21:17] frames_held,
  // [22] send_busy, [23] zero
  output logic [sfdq_pkg::M_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast,
  // apb configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sfdq_pkg::*;

  ctl_cmd_t   ctl;
  dp_sts_t    sts;
  logic       cfg_we;
  logic [7:0] start_pattern;

  // zero-wait apb, writes land in the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_START_PATTERN);
  assign prdata = (paddr[2] == REG_START_PATTERN) ? {24'b0, start_pattern} : '0;

  // sequencer
  sfdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // queue, send state and result register
  sfdq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[7:0]),
    .start_pattern (start_pattern),
    .ctl           (ctl),
    .sts           (sts)
  );

endmodule

// File: rtl/sfdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdq_checker
// port-level checks of the spi frame deframer queue
// ----------------------------------------------------------------------------
module sfdq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [sfdq_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser,
  input logic                           m_tlast
);
  import sfdq_pkg::*;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // no result comes out of reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one command at a time: no acceptance right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after a transaction");

  // an empty pop answers with a single result
  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_EMPTY) |-> m_tlast)
    else $error("empty status without tlast");

  // the queue never reports more frames than its depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:17] <= 5'(QUEUE_FRAMES)))
    else $error("frames_held beyond queue depth");

endmodule

bind spi_frame_deframer_queue sfdq_checker u_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the spi frame deframer queue
// ----------------------------------------------------------------------------
// commands go in on the slave stream in bursts with random gaps, results are
// taken on the master stream under a changing stall pattern. a class keeps its
// own copy of the frame queue, the receive framing and the transmit sender and
// turns each accepted command into the result transactions it should cause;
// every result is compared field by field against the oldest one due. the
// start pattern register is rewritten between phases (reset value, 0, 255,
// random) while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import sfdq_pkg::*;

  // register 0 sits at byte address 0
  localparam logic [2:0] ADDR_START_PATTERN = 3'd0;
  localparam int         PHASE_ITEMS        = 125;
  localparam int         SETTLE_CYCLES      = 24;     // longer than a full pop
  localparam int         IDLE_WAIT_LIMIT    = 200000;
  localparam int         RUN_LIMIT_NS       = 4000000;

  // one expected result transaction
  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] frame_byte;
    logic       last;
    status_t    status;
    logic [4:0] frames_held;
    logic       send_busy;
  } frame_result_t;

  // one command transaction
  typedef struct {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic [4:0] tx_index;
    logic [7:0] tx_data;
  } spi_cmd_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the queue, framing and sender state
  // --------------------------------------------------------------------------
  class frame_queue_tracker;
    logic [7:0]    start_pat;
    logic [7:0]    frame_mem [QUEUE_FRAMES][FRAME_BYTES];
    logic [7:0]    tx_frame [FRAME_BYTES];
    int            wr_slot, rd_slot, held, rx_pos, tx_pos;
    bit            armed, sending;
    frame_result_t result_due_q[$];
    int            errors, checked, commands;
    int            full_drops, busy_rejects, empty_pops, frames_popped, bytes_sent;

    function new();
      start_pat = START_PATTERN_RESET;
      foreach (tx_frame[i]) tx_frame[i] = 8'h00;
      wr_slot = 0; rd_slot = 0; held = 0; rx_pos = 0; tx_pos = 0;
      armed = 0; sending = 0;
      errors = 0; checked = 0; commands = 0;
      full_drops = 0; busy_rejects = 0; empty_pops = 0; frames_popped = 0;
      bytes_sent = 0;
    endfunction

    // frames_held and send_busy reflect state after the command took effect
    function void due(logic txv, logic [7:0] txb, logic [7:0] fb, logic lst,
                      status_t st);
      frame_result_t r;
      r.tx_valid = txv; r.tx_byte = txb; r.frame_byte = fb; r.last = lst;
      r.status = st; r.frames_held = 5'(held); r.send_busy = sending;
      result_due_q.push_back(r);
    endfunction

    // apply one accepted command and queue its expected results
    function void note_command(spi_cmd_t c);
      status_t    st;
      logic       txv;
      logic [7:0] txb;
      int         slot;
      commands++;
      case (c.cmd)
        CMD_XFER: begin
          st = STAT_OK; txv = 0; txb = 8'h00;
          if (held >= QUEUE_FRAMES) begin
            // queue full: byte dropped whether armed or not
            st = STAT_FULL;
            full_drops++;
          end else if (armed) begin
            frame_mem[wr_slot][rx_pos] = c.rx_byte;
            rx_pos++;
            if (rx_pos >= FRAME_BYTES) begin
              rx_pos  = 0;
              wr_slot = (wr_slot + 1) % QUEUE_FRAMES;
              held++;
              armed   = 0;
            end
          end
          // arming comes after storing, so a start byte ending a frame re-arms
          if (c.rx_byte == start_pat) armed = 1;
          if (sending) begin
            txv = 1;
            txb = tx_frame[tx_pos];
            bytes_sent++;
            tx_pos++;
            if (tx_pos >= FRAME_BYTES) begin
              sending = 0;
              tx_pos  = 0;
            end
          end
          due(txv, txb, 8'h00, 1'b1, st);
        end
        CMD_POP: begin
          if (held == 0) begin
            empty_pops++;
            due(1'b0, 8'h00, 8'h00, 1'b1, STAT_EMPTY);
          end else begin
            slot    = rd_slot;
            rd_slot = (rd_slot + 1) % QUEUE_FRAMES;
            held--;
            frames_popped++;
            for (int i = 0; i < FRAME_BYTES; i++)
              due(1'b0, 8'h00, frame_mem[slot][i], i == FRAME_BYTES - 1, STAT_OK);
          end
        end
        CMD_TXW: begin
          if (sending) begin
            busy_rejects++;
            due(1'b0, 8'h00, 8'h00, 1'b1, STAT_BUSY);
          end else begin
            if (c.tx_index < FRAME_BYTES) tx_frame[c.tx_index] = c.tx_data;
            due(1'b0, 8'h00, 8'h00, 1'b1, STAT_OK);
          end
        end
        default: begin
          if (sending) begin
            busy_rejects++;
            due(1'b0, 8'h00, 8'h00, 1'b1, STAT_BUSY);
          end else begin
            sending = 1;
            tx_pos  = 0;
            due(1'b1, start_pat, 8'h00, 1'b1, STAT_OK);
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %h want %h", checked, name, got, want));
    endtask

    task check_result(logic [M_TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
      frame_result_t r;
      if (result_due_q.size() == 0) begin
        report($sformatf("result with none due, tdata %h", tdata));
        return;
      end
      r = result_due_q.pop_front();
      check_field("tx_valid", tdata[0], r.tx_valid);
      check_field("tx_byte", tdata[8:1], r.tx_byte);
      check_field("frame_byte", tdata[16:9], r.frame_byte);
      check_field("frames_held", tdata[21:17], r.frames_held);
      check_field("send_busy", tdata[22], r.send_busy);
      check_field("status", tuser, r.status);
      check_field("last", tlast, r.last);
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // dut connections
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [7:0] rx_byte, [12:8] tx_index, [20:13] tx_data
  logic [1:0]           s_tuser;   // [1:0] command
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [0] tx_valid, [8:1] tx_byte, [16:9] frame_byte,
                                   // [21:17] frames_held, [22] send_busy
  logic [1:0]           m_tuser;   // [1:0] status
  logic                 m_tlast;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  spi_frame_deframer_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  frame_queue_tracker tracker;
  spi_cmd_t           cmd_q[$];

  // 250 MHz clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("spi_frame_deframer_queue regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: check each accepted transaction, then pick the next stall
  // --------------------------------------------------------------------------
  typedef enum int {
    RX_FREE,    // always ready
    RX_MOSTLY,  // ready at random, with odds of three in four
    RX_SPARSE,  // ready at random, with odds of one in four
    RX_BURSTY   // ready with occasional long holds
  } rx_stall_t;

  rx_stall_t stall_mode;
  int        mode_left;
  int        hold_left;
  logic      ready_next;

  initial begin
    stall_mode = RX_FREE;
    mode_left  = 0;
    hold_left  = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(m_tdata, m_tuser, m_tlast);
    if (mode_left == 0) begin
      stall_mode = rx_stall_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(30, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      RX_FREE:   ready_next = 1'b1;
      RX_MOSTLY: ready_next = ($urandom_range(0, 3) != 0);
      RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 16);
        end
      end
    endcase
    m_tready <= ready_next;
  end

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  function void add_cmd(cmd_t c, logic [7:0] rx, logic [4:0] idx, logic [7:0] d);
    spi_cmd_t t;
    t.cmd = c; t.rx_byte = rx; t.tx_index = idx; t.tx_data = d;
    cmd_q.push_back(t);
  endfunction

  // unused fields carry random content
  function void add_xfer(logic [7:0] rx);
    add_cmd(CMD_XFER, rx, 5'($urandom), 8'($urandom));
  endfunction

  // start byte then up to a full frame, now and then the start byte as data
  function void add_frame(logic [7:0] pat, int nbytes);
    add_xfer(pat);
    for (int i = 0; i < nbytes; i++)
      add_xfer(($urandom_range(0, 9) == 0) ? pat : 8'($urandom));
  endfunction

  // load some transmit bytes, start the send, then clock bytes out
  function void add_send_run();
    int nwr;
    int nxfer;
    nwr = $urandom_range(0, 4);
    for (int i = 0; i < nwr; i++)
      add_cmd(CMD_TXW, 8'($urandom),
              ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, FRAME_BYTES - 1))
                                          : 5'($urandom),
              8'($urandom));
    add_cmd(CMD_SEND, 8'($urandom), 5'($urandom), 8'($urandom));
    nxfer = $urandom_range(0, FRAME_BYTES + 2);
    for (int i = 0; i < nxfer; i++) add_xfer(8'($urandom));
  endfunction

  function void build_directed();
    logic [7:0] pat;
    pat = START_PATTERN_RESET;
    add_cmd(CMD_POP, 8'hFF, 5'h1F, 8'hFF);          // pop with nothing queued
    add_cmd(CMD_TXW, 8'h00, 5'd0, 8'hFF);
    add_cmd(CMD_TXW, 8'h00, 5'(FRAME_BYTES - 1), 8'h00);
    add_cmd(CMD_TXW, 8'h00, 5'(FRAME_BYTES), 8'h55); // index past the frame
    add_cmd(CMD_TXW, 8'h00, 5'h1F, 8'hAA);
    add_cmd(CMD_SEND, 8'h00, 5'd0, 8'h00);
    add_cmd(CMD_SEND, 8'h00, 5'd0, 8'h00);          // start while already sending
    add_cmd(CMD_TXW, 8'h00, 5'd1, 8'h12);           // write while sending
    add_xfer(pat);                                   // arm, first transmit byte
    // start byte inside the frame and as its last byte
    add_xfer(8'h00);
    add_xfer(8'hFF);
    add_xfer(pat);
    add_xfer(8'h5A);
    add_xfer(8'hA5);
    add_xfer(8'h01);
    add_xfer(8'h80);
    add_xfer(pat);                                   // completes frame, re-arms
    add_cmd(CMD_POP, 8'h00, 5'h00, 8'h00);
    for (int i = 0; i < FRAME_BYTES; i++) add_xfer(8'(8'hF0 + i));
    add_cmd(CMD_POP, 8'h00, 5'h00, 8'h00);
    add_cmd(CMD_POP, 8'h00, 5'h00, 8'h00);          // empty again
  endfunction

  // mostly well-formed frames and send runs, some noise and cut-off frames
  function void build_random(int count, logic [7:0] pat);
    int pick;
    while (cmd_q.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        add_frame(pat, FRAME_BYTES);
      else if (pick < 55)
        add_cmd(CMD_POP, 8'($urandom), 5'($urandom), 8'($urandom));
      else if (pick < 72)
        add_send_run();
      else if (pick < 80)
        add_frame(pat, $urandom_range(0, FRAME_BYTES - 1));
      else
        add_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom), 5'($urandom), 8'($urandom));
    end
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // wait for all due results, then let the block settle
  task automatic wait_idle();
    int cycles;
    cycles = 0;
    do begin
      @(posedge clk);
      cycles++;
    end while (tracker.result_due_q.size() != 0 && cycles < IDLE_WAIT_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_pattern(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_START_PATTERN;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.start_pat = value;
  endtask

  // push the command queue through the slave stream in bursts
  task automatic send_commands();
    spi_cmd_t c;
    int       burst;
    int       gap;
    int       n;
    int       half;
    burst = $urandom_range(1, 24);
    half  = cmd_q.size() / 2;
    n     = 0;
    while (cmd_q.size() != 0) begin
      c = cmd_q.pop_front();
      if (n == half) begin
        // hold off until the block has drained everything
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.result_due_q.size() != 0);
      end else if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {3'b000, c.tx_data, c.tx_index, c.rx_byte};
      s_tuser  <= c.cmd;
      do @(posedge clk); while (!s_tready);
      tracker.note_command(c);
      if (burst > 0) burst--;
      n++;
    end
    s_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] patterns [4];
    tracker  = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_XFER;
    m_tready <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= ADDR_START_PATTERN;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed checks under the reset start pattern
    build_directed();
    send_commands();
    wait_idle();

    // random phases, start pattern rewritten while idle
    patterns[0] = 8'h00;
    patterns[1] = 8'hFF;
    patterns[2] = 8'($urandom);
    patterns[3] = START_PATTERN_RESET;
    foreach (patterns[p]) begin
      write_start_pattern(patterns[p]);
      build_random(PHASE_ITEMS, patterns[p]);
      send_commands();
      wait_idle();
    end

    if (tracker.result_due_q.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.result_due_q.size()));

    $display("covered %0d commands, %0d results; %0d frames popped, %0d empty pops",
             tracker.commands, tracker.checked, tracker.frames_popped, tracker.empty_pops);
    $display("queue-full drops %0d, busy rejects %0d, bytes sent %0d, %0d mismatches",
             tracker.full_drops, tracker.busy_rejects, tracker.bytes_sent, tracker.errors);
    if (tracker.errors == 0) begin
      $display("spi_frame_deframer_queue regression: pass");
    end else begin
      $display("spi_frame_deframer_queue regression: fail");
    end
    $finish;
  end

endmodule
